FILE: sv/fmmp_pkg.sv
// shared types and constants for the fibonacci modular matrix power unit
package fmmp_pkg;
	localparam int unsigned IdxW = 64;
	localparam int unsigned ModW = 31;
	localparam logic [ModW-1:0] ModReset = 31'd1000000007;

	typedef logic [IdxW-1:0] index_t;
	typedef logic [ModW-1:0] value_t;
endpackage

FILE: sv/fmmp_if.sv
// valid/ready channel interfaces for index and result words
interface fmmp_index_if;
	logic valid;
	logic ready;
	fmmp_pkg::index_t index;
	modport source (output valid, output index, input ready);
	modport sink (input valid, input index, output ready);
endinterface

interface fmmp_result_if;
	logic valid;
	logic ready;
	fmmp_pkg::value_t fib_value;
	modport source (output valid, output fib_value, input ready);
	modport sink (input valid, input fib_value, output ready);
endinterface

FILE: sv/fmmp_modred.sv
// bit-serial modular reduction of a 63-bit sum, one bit per cycle
module fmmp_modred (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [62:0] sum,
	input  fmmp_pkg::value_t modulus,
	output logic done,
	output fmmp_pkg::value_t rem
);
	import fmmp_pkg::*;

	logic [62:0] sum_q;
	logic [ModW:0] rem_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [ModW+1:0] trial;

	// shift in next bit and subtract modulus when it fits
	assign trial = {1'b0, rem_q[ModW-1:0], sum_q[62]} - {2'b00, modulus};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd62;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sum_q <= sum;
			rem_q <= '0;
		end else if (busy_q) begin
			sum_q <= {sum_q[61:0], 1'b0};
			if (!trial[ModW+1])
				rem_q <= trial[ModW:0];
			else
				rem_q <= {rem_q[ModW-1:0], sum_q[62]};
		end
	end

	assign rem = rem_q[ModW-1:0];
endmodule

FILE: sv/fibonacci_mod_matrix_power_unit.sv
// Fibonacci F(n) mod modulus by 2x2 matrix square-and-multiply on one shared multiplier.
// One index takes a variable time. Each matrix entry passes two multiplier states (MUL0,
// MUL1), a state that starts the reduction (RED) and a wait (WAIT) until the bit-serial
// reduction of the 63-bit sum is done. Four entries make one matrix product. Each
// processed bit of n-1 costs one decision state (BIT) plus a squaring product, and one
// more product when the bit is set. One last decision state then raises the result. For
// F(0), or for a modulus below two, the result is valid in the cycle after the index is
// taken. The single 31x31 multiplier and the serial remainder unit bound the speed. Ready
// is low while a word is in work; the result register holds one finished word until taken.
module fibonacci_mod_matrix_power_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  fmmp_pkg::value_t cfg_wdata,
	fmmp_index_if.sink idx_ch,
	fmmp_result_if.source res_ch
);
	import fmmp_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_BIT  = 7'b0000010,
		ST_MUL0 = 7'b0000100,
		ST_MUL1 = 7'b0001000,
		ST_RED  = 7'b0010000,
		ST_WAIT = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t state_q;
	value_t modulus_q;
	index_t n_q;
	value_t a_q [4];
	value_t b_q [4];
	value_t r_q [4];
	logic [1:0] ent_q;
	logic sq_q;
	logic [61:0] prod_q;
	logic [62:0] sum_q;
	logic red_start;
	logic red_done;
	value_t red_rem;
	value_t res_q;
	logic [1:0] i0, i1, j0, j1;
	value_t xa, xb;
	logic [61:0] prod;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) modulus_q <= ModReset;
		else if (cfg_we) modulus_q <= cfg_wdata;
	end

	// operand selection: entry (i,j) = x[i][0]*y[0][j] + x[i][1]*y[1][j]
	always_comb begin
		i0 = {ent_q[1], 1'b0};
		i1 = {ent_q[1], 1'b1};
		j0 = {1'b0, ent_q[0]};
		j1 = {1'b1, ent_q[0]};
		if (state_q == ST_MUL0) begin
			xa = sq_q ? b_q[i0] : a_q[i0];
			xb = b_q[j0];
		end else begin
			xa = sq_q ? b_q[i1] : a_q[i1];
			xb = b_q[j1];
		end
	end

	// shared multiplier
	assign prod = 62'(xa) * 62'(xb);

	assign red_start = (state_q == ST_RED);

	fmmp_modred u_red (
		.clk(clk), .arst_n(arst_n), .start(red_start), .sum(sum_q),
		.modulus(modulus_q), .done(red_done), .rem(red_rem)
	);

	assign idx_ch.ready = (state_q == ST_IDLE);
	assign res_ch.valid = (state_q == ST_OUT);
	assign res_ch.fib_value = res_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ent_q <= '0;
			sq_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (idx_ch.valid) begin
					if (idx_ch.index == '0 || modulus_q < 31'd2) state_q <= ST_OUT;
					else state_q <= ST_BIT;
				end
				ST_BIT: begin
					ent_q <= '0;
					if (n_q == '0) state_q <= ST_OUT;
					else begin
						sq_q <= !n_q[0];
						state_q <= ST_MUL0;
					end
				end
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_RED;
				ST_RED: state_q <= ST_WAIT;
				ST_WAIT: if (red_done) begin
					ent_q <= ent_q + 2'd1;
					if (ent_q != 2'd3) state_q <= ST_MUL0;
					else if (sq_q) state_q <= ST_BIT;
					else begin
						sq_q <= 1'b1;
						state_q <= ST_MUL0;
					end
				end
				ST_OUT: if (res_ch.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				n_q <= idx_ch.index - 64'd1;
				a_q[0] <= 31'd1; a_q[1] <= '0; a_q[2] <= '0; a_q[3] <= 31'd1;
				b_q[0] <= 31'd1; b_q[1] <= 31'd1; b_q[2] <= 31'd1; b_q[3] <= '0;
				res_q <= '0;
			end
			ST_BIT: if (n_q == '0) res_q <= a_q[0];
			ST_MUL0: prod_q <= prod;
			ST_MUL1: sum_q <= {1'b0, prod_q} + {1'b0, prod};
			ST_WAIT: if (red_done) begin
				r_q[ent_q] <= red_rem;
				if (ent_q == 2'd3) begin
					if (sq_q) begin
						b_q[0] <= r_q[0]; b_q[1] <= r_q[1];
						b_q[2] <= r_q[2]; b_q[3] <= red_rem;
						n_q <= n_q >> 1;
					end else begin
						a_q[0] <= r_q[0]; a_q[1] <= r_q[1];
						a_q[2] <= r_q[2]; a_q[3] <= red_rem;
					end
				end
			end
			default: ;
		endcase
	end
endmodule

FILE: sv/fmmp_checker.sv
// port-level checker for the fibonacci modular matrix power unit
module fmmp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input fmmp_pkg::value_t fib_value
);
	// no new word accepted while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("ready while result pending");
	// result held while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fib_value))
		else $error("result dropped");
	// accepted word leaves ready low next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after accept");
	// ready returns only after a result is taken
	a_ret: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> $past(out_valid && out_ready)) else $error("spurious ready");
endmodule

bind fibonacci_mod_matrix_power_unit fmmp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(idx_ch.valid), .in_ready(idx_ch.ready),
	.out_valid(res_ch.valid), .out_ready(res_ch.ready), .fib_value(res_ch.fib_value)
);
